FILE: rtl/bcg_pkg.sv
// shared types, constants and cosine tables of the beat click generator
`default_nettype none

package bcg_pkg;

	// configurable structure
	localparam int PHASE_BITS     = 24;
	localparam int COS_TABLE_BITS = 10;
	localparam int BEATS_PER_BAR  = 4;

	// field widths
	localparam int POS_W      = 48;
	localparam int FRAC_W     = 16;
	localparam int BEAT_INT_W = POS_W - FRAC_W;
	localparam int SAMPLE_W   = 24;
	localparam int STEP_W     = 23;
	localparam int COEF_W     = 16;
	localparam int ENV_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// envelope full scale and jump threshold (one beat)
	localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);
	localparam int JUMP_LIMIT = 65536;

	// cosine lookup
	localparam int COS_W     = 15;
	localparam int QUARTER_W = COS_TABLE_BITS - 2;
	localparam int QUARTER   = 1 << QUARTER_W;
	localparam int PX_W      = PHASE_BITS + COS_TABLE_BITS;

	// bar position of the integer beat
	localparam int REM_W = $clog2(BEATS_PER_BAR + 1);
	// remainder of the bias 2^31 that turns the signed beat into an unsigned one
	localparam logic [REM_W-1:0] BIAS_REM =
		REM_W'((64'd1 << (BEAT_INT_W - 1)) % BEATS_PER_BAR);

	// shared multiplier
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int MAG_W   = 25;
	localparam int MIX_W   = 27;
	localparam int RND_POS = 22;

	// fixed-point constants of the series
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1 <<< 30;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_COS,
		ST_MUL_ENV,
		ST_MUL_GAIN,
		ST_MIX,
		ST_DECAY,
		ST_OUT
	} bcg_state_t;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEAT_STEP     = 3'd0,
		REG_DOWNBEAT_STEP = 3'd1,
		REG_DECAY_COEFF   = 3'd2,
		REG_CLICK_GAIN    = 3'd3,
		REG_SILENT_LEVEL  = 3'd4
	} bcg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic cos_fetch;
		logic mul_env;
		logic mul_gain;
		logic mix;
		logic decay;
		logic load_out;
	} bcg_cmd_t;

	typedef logic [COS_W-1:0] cos_table_t [QUARTER];

	// cos of r steps of a quarter turn over QUARTER, taylor series to a^10 in q2.30, rounded to q0.15
	function automatic int quarter_cos(int r);
		longint theta;
		longint t2;
		longint acc;
		theta = (longint'(r) * HALF_PI_Q30) >>> QUARTER_W;
		t2 = (theta * theta) >>> 30;
		acc = ONE_Q30;
		acc = ONE_Q30 - ((t2 * acc) >>> 30) / 90;
		if (acc < 0) acc = 0;
		acc = ONE_Q30 - ((t2 * acc) >>> 30) / 56;
		if (acc < 0) acc = 0;
		acc = ONE_Q30 - ((t2 * acc) >>> 30) / 30;
		if (acc < 0) acc = 0;
		acc = ONE_Q30 - ((t2 * acc) >>> 30) / 12;
		if (acc < 0) acc = 0;
		acc = ONE_Q30 - ((t2 * acc) >>> 30) / 2;
		if (acc < 0) acc = 0;
		acc = (acc + (64'sd1 <<< 14)) >>> 15;
		if (acc > 32767) acc = 32767;
		return int'(acc);
	endfunction

	// cosine rows, or sine rows taken as cos of the complement angle
	function automatic cos_table_t build_cos_table(bit sine);
		cos_table_t tbl;
		for (int r = 0; r < QUARTER; r++) begin
			tbl[r] = COS_W'(quarter_cos(sine ? (QUARTER - r) : r));
		end
		return tbl;
	endfunction

	localparam cos_table_t COS_TABLE = build_cos_table(1'b0);
	localparam cos_table_t SIN_TABLE = build_cos_table(1'b1);

endpackage

`default_nettype wire

FILE: rtl/bcg_ctrl.sv
// sequencing state machine of the beat click generator
`default_nettype none

module bcg_ctrl
	import bcg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	output bcg_cmd_t         cmd
);

	bcg_state_t state_q;
	bcg_state_t state_d;
	logic       out_valid_q;

	// state register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_COS;
			end
			ST_COS: begin
				cmd.cos_fetch = 1'b1;
				state_d       = ST_MUL_ENV;
			end
			ST_MUL_ENV: begin
				cmd.mul_env = 1'b1;
				state_d     = ST_MUL_GAIN;
			end
			ST_MUL_GAIN: begin
				cmd.mul_gain = 1'b1;
				state_d      = ST_MIX;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_DECAY;
			end
			ST_DECAY: begin
				cmd.decay = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/bcg_dpath.sv
// datapath of the beat click generator: registers, trigger logic, cosine, multiplier, mixer
`default_nettype none

module bcg_dpath
	import bcg_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire bcg_cmd_t               cmd,
	input  wire logic                   cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic signed [POS_W-1:0]    beat_position,
	input  wire logic                   block_start,
	input  wire logic                   click_enable,
	input  wire logic signed [SAMPLE_W-1:0] in_left,
	input  wire logic signed [SAMPLE_W-1:0] in_right,
	output logic signed [SAMPLE_W-1:0]  out_left,
	output logic signed [SAMPLE_W-1:0]  out_right,
	output logic                        click_started
);

	// configuration
	logic [STEP_W-1:0] beat_step_q;
	logic [STEP_W-1:0] downbeat_step_q;
	logic [COEF_W-1:0] decay_q;
	logic [COEF_W-1:0] gain_q;
	logic [ENV_W-1:0]  silent_q;

	// captured transaction
	logic signed [POS_W-1:0]    beat_q;
	logic                       block_q;
	logic                       enable_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;

	// click state
	logic signed [POS_W-1:0] prev_q;
	logic                    pos_valid_q;
	logic [ENV_W-1:0]        env_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [STEP_W-1:0]       step_q;

	// per-transaction work registers
	logic                   trig_q;
	logic [COS_W-1:0]       cos_mag_q;
	logic                   cos_neg_q;
	logic                   audible_q;
	logic [PROD_W-1:0]      prod_q;
	logic signed [SAMPLE_W-1:0] res_left_q;
	logic signed [SAMPLE_W-1:0] res_right_q;

	// output register
	logic signed [SAMPLE_W-1:0] out_left_q;
	logic signed [SAMPLE_W-1:0] out_right_q;
	logic                       started_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_step_q     <= STEP_W'(65536);
			downbeat_step_q <= STEP_W'(131072);
			decay_q         <= COEF_W'(65500);
			gain_q          <= COEF_W'(16384);
			silent_q        <= ENV_W'(1);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				REG_BEAT_STEP:     beat_step_q     <= cfg_data[STEP_W-1:0];
				REG_DOWNBEAT_STEP: downbeat_step_q <= cfg_data[STEP_W-1:0];
				REG_DECAY_COEFF:   decay_q         <= cfg_data[COEF_W-1:0];
				REG_CLICK_GAIN:    gain_q          <= cfg_data[COEF_W-1:0];
				REG_SILENT_LEVEL:  silent_q        <= cfg_data[ENV_W-1:0];
				default: ;
			endcase
		end
	end

	// jump check and trigger
	logic signed [POS_W:0] pos_diff;
	logic                  far_jump;
	logic                  reload;
	logic                  trig;

	assign pos_diff = {beat_q[POS_W-1], beat_q} - {prev_q[POS_W-1], prev_q};
	assign far_jump = (pos_diff > (POS_W+1)'(JUMP_LIMIT))
		|| (pos_diff < -(POS_W+1)'(JUMP_LIMIT));
	assign reload   = block_q && (!pos_valid_q || far_jump);
	assign trig     = enable_q && !reload
		&& ($signed(beat_q[POS_W-1:FRAC_W]) > $signed(prev_q[POS_W-1:FRAC_W]));

	// bar position of the biased beat, its remainder modulo the bar length
	logic [BEAT_INT_W-1:0] beat_biased;
	logic                  downbeat;

	assign beat_biased = {~beat_q[POS_W-1], beat_q[POS_W-2:FRAC_W]};
	assign downbeat    =
		(REM_W'(beat_biased % BEAT_INT_W'(BEATS_PER_BAR)) == BIAS_REM);

	// cosine lookup by quadrant
	logic [PX_W-1:0]           phase_ext;
	logic [COS_TABLE_BITS-1:0] cos_idx;
	logic [1:0]                cos_quad;
	logic [QUARTER_W-1:0]      cos_r;
	logic [COS_W-1:0]          cos_val;

	assign phase_ext = {phase_q, {COS_TABLE_BITS{1'b0}}};
	assign cos_idx   = phase_ext[PX_W-1 -: COS_TABLE_BITS];
	assign cos_quad  = cos_idx[COS_TABLE_BITS-1 -: 2];
	assign cos_r     = cos_idx[QUARTER_W-1:0];
	assign cos_val   = cos_quad[0] ? SIN_TABLE[cos_r] : COS_TABLE[cos_r];

	// shared multiplier operand select
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod_d;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		priority if (cmd.mul_env) begin
			mul_a = MUL_A_W'(cos_mag_q);
			mul_b = MUL_B_W'(env_q);
		end else if (cmd.mul_gain) begin
			mul_a = prod_q[MUL_A_W-1:0];
			mul_b = MUL_B_W'(gain_q);
		end else if (cmd.mix) begin
			mul_a = MUL_A_W'(env_q);
			mul_b = MUL_B_W'(decay_q);
		end
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

	// click value and saturated mix
	logic [PROD_W-1:0]        prod_rnd;
	logic [MAG_W-1:0]         click_mag;
	logic signed [MIX_W-1:0]  click_val;
	logic signed [MIX_W-1:0]  sum_left;
	logic signed [MIX_W-1:0]  sum_right;

	assign prod_rnd  = prod_q + (PROD_W'(1) << RND_POS);
	assign click_mag = prod_rnd[RND_POS+MAG_W:RND_POS+1];
	assign click_val = cos_neg_q ? -$signed(MIX_W'(click_mag)) : $signed(MIX_W'(click_mag));
	assign sum_left  = MIX_W'(left_q) + click_val;
	assign sum_right = MIX_W'(right_q) + click_val;

	function automatic logic signed [SAMPLE_W-1:0] sat24(logic signed [MIX_W-1:0] v);
		logic signed [MIX_W-1:0] hi;
		logic signed [MIX_W-1:0] lo;
		hi = MIX_W'((1 << (SAMPLE_W - 1)) - 1);
		lo = -MIX_W'(1 << (SAMPLE_W - 1));
		if (v > hi) begin
			return hi[SAMPLE_W-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_W-1:0];
		end
		return v[SAMPLE_W-1:0];
	endfunction

	// click state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			pos_valid_q <= 1'b0;
			env_q       <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			trig_q      <= 1'b0;
		end else begin
			if (cmd.check) begin
				prev_q <= beat_q;
				trig_q <= trig;
				if (block_q) begin
					pos_valid_q <= 1'b1;
				end
				if (trig) begin
					env_q   <= ENV_ONE;
					phase_q <= '0;
					// downbeat tone on the first beat of a bar
					step_q  <= downbeat ? downbeat_step_q : beat_step_q;
				end
			end
			if (cmd.decay) begin
				if (audible_q) begin
					env_q   <= prod_q[FRAC_W+ENV_W-1:FRAC_W];
					phase_q <= phase_q + PHASE_BITS'(step_q);
				end else begin
					env_q <= '0;
				end
			end
		end
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			beat_q   <= beat_position;
			block_q  <= block_start;
			enable_q <= click_enable;
			left_q   <= in_left;
			right_q  <= in_right;
		end
		if (cmd.cos_fetch) begin
			cos_mag_q <= cos_val;
			cos_neg_q <= cos_quad[1] ^ cos_quad[0];
			audible_q <= env_q > silent_q;
		end
		if (cmd.mul_env || cmd.mul_gain || cmd.mix) begin
			prod_q <= prod_d;
		end
		if (cmd.mix) begin
			if (audible_q) begin
				res_left_q  <= sat24(sum_left);
				res_right_q <= sat24(sum_right);
			end else begin
				res_left_q  <= left_q;
				res_right_q <= right_q;
			end
		end
		if (cmd.load_out) begin
			out_left_q  <= res_left_q;
			out_right_q <= res_right_q;
			started_q   <= trig_q;
		end
	end

	assign out_left      = out_left_q;
	assign out_right     = out_right_q;
	assign click_started = started_q;

endmodule

`default_nettype wire

FILE: rtl/beat_click_generator.sv
// top level of the beat click generator
//
// One input transaction per audio sample carries the beat position (signed
// q31.16), block start and enable flags and a stereo sample; one output
// transaction per input returns the stereo sample with the click mixed in
// and a flag set when that sample started a click. Both channels use
// valid/ready.
// Each sample passes in order through the accept step, the jump and trigger
// check, the cosine lookup, three passes through the single shared 32x17
// multiplier, the decay step and the load of the output register, which
// waits while that register is full; a new sample is accepted only once
// the previous one has finished its pass.
// A stalled receiver holds the finished result in the output register; the
// next sample is still accepted and processed, and waits for that register
// only at the end of its own pass.
// Configuration is a write-only register port (index, data, write enable),
// to be written only with no sample in flight; the block does not enforce this.
// Reset restores the register defaults, clears the beat history, the click
// envelope and phase, and empties the output register.
`default_nettype none

module beat_click_generator
	import bcg_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic signed [POS_W-1:0]    beat_position,
	input  wire logic                       block_start,
	input  wire logic                       click_enable,
	input  wire logic signed [SAMPLE_W-1:0] in_left,
	input  wire logic signed [SAMPLE_W-1:0] in_right,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic signed [SAMPLE_W-1:0]      out_left,
	output logic signed [SAMPLE_W-1:0]      out_right,
	output logic                            click_started
);

	bcg_cmd_t cmd;

	// sequencer
	bcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// arithmetic and state
	bcg_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.beat_position (beat_position),
		.block_start   (block_start),
		.click_enable  (click_enable),
		.in_left       (in_left),
		.in_right      (in_right),
		.out_left      (out_left),
		.out_right     (out_right),
		.click_started (click_started)
	);

endmodule

`default_nettype wire

FILE: rtl/bcg_checker.sv
// port-level assertions of the beat click generator and their bind
`default_nettype none

module bcg_checker
	import bcg_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic signed [SAMPLE_W-1:0] out_left,
	input wire logic signed [SAMPLE_W-1:0] out_right,
	input wire logic                       click_started
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_left) && $stable(out_right)
			&& $stable(click_started))
		else $error("result payload changed while stalled");

	// one sample in flight: input closes right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while one is in progress");

	// a result only appears at the end of a pass, never while idle
	a_result_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a processing pass");

endmodule

bind beat_click_generator bcg_checker u_bcg_checker (.*);

`default_nettype wire
